@@ hdl/mrne_pkg.sv @@
package mrne_pkg;

	// Table size and derived index widths.
	localparam int MAX_NOTES = 32;
	localparam int NA_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int NC_W = $clog2(MAX_NOTES + 1);

	// Operation codes.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// Status byte bases.
	localparam logic [7:0] NOTE_OFF_BASE = 8'h80;
	localparam logic [7:0] NOTE_ON_BASE = 8'h90;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] channel;
		logic [6:0] note_key;
		logic [7:0] release_velocity;
		logic [31:0] ticks;
		logic cut_notes;
	} cmd_t;

	typedef struct packed {
		logic event_valid;
		logic [31:0] delta_ticks;
		logic [7:0] status_byte;
		logic [6:0] event_key;
		logic [6:0] event_velocity;
		logic [31:0] remaining_ticks;
		logic [5:0] expired_count;
		logic last;
	} evt_t;

	// One entry of the note table.
	typedef struct packed {
		logic [3:0] ch;
		logic [6:0] key;
		logic [7:0] vel;
		logic [31:0] left;
	} note_t;

endpackage

@@ hdl/midi_running_note_expiry.sv @@
// Channel | Direction | Handshake            | Beat payload
// cmd     | in        | cmd_valid, cmd_stall | mrne_pkg::cmd_t (one command)
// evt     | out       | evt_valid, evt_stall | mrne_pkg::evt_t (one result)
//
// One command is handled at a time; cmd_stall stays high until its last result is registered.
// An advance runs passes over the note table, which has one write and one registered read port:
// each pass is a minimum sweep and a subtract/compact sweep. A flush first sweeps the table
// to clip notes or raise the reference, and then runs the passes.
// Reset clears the note count and all control state; the table contents need no clearing.
// A stalled output pauses the sweep only when a further release has to be handed over.
module midi_running_note_expiry (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input mrne_pkg::cmd_t cmd,
	output logic evt_valid,
	input logic evt_stall,
	output mrne_pkg::evt_t evt
);
	import mrne_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FL_RD = 4'd1;
	localparam logic [3:0] ST_FL_EV = 4'd2;
	localparam logic [3:0] ST_MIN_START = 4'd3;
	localparam logic [3:0] ST_MIN_RD = 4'd4;
	localparam logic [3:0] ST_MIN_EV = 4'd5;
	localparam logic [3:0] ST_MIN_CHK = 4'd6;
	localparam logic [3:0] ST_SUB_RD = 4'd7;
	localparam logic [3:0] ST_SUB_EV = 4'd8;
	localparam logic [3:0] ST_FINISH = 4'd9;

	logic [3:0] state_q;
	logic [NC_W-1:0] count_q;
	logic [NC_W-1:0] idx_q;
	logic [NC_W-1:0] wr_q;
	logic [NC_W-1:0] n_q;
	logic [31:0] delay_q;
	logic [31:0] min_q;
	logic cut_q;
	logic first_q;
	logic pend_v_q;
	evt_t pend_q;
	logic out_v_q;
	evt_t out_q;

	note_t mem [MAX_NOTES];
	note_t rdata_q;

	logic mem_we;
	logic [NA_W-1:0] mem_waddr;
	note_t mem_wdata;
	logic cmd_take;
	logic out_free;
	logic out_load;
	logic [31:0] new_left;
	evt_t new_ev;
	evt_t fin_ev;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take = cmd_valid && !cmd_stall;
	assign out_free = !out_v_q || !evt_stall;
	assign evt_valid = out_v_q;
	assign evt = out_q;

	// The output register loads on a handover during the compact sweep or at finish.
	assign out_load = ((state_q == ST_SUB_EV) && (new_left == 32'd0) && pend_v_q && out_free)
		|| ((state_q == ST_FINISH) && out_free);

	// Shared subtractor: ticks left after the current step.
	assign new_left = rdata_q.left - min_q;

	// Release event built from the entry just read.
	always_comb begin
		new_ev = '0;
		new_ev.event_valid = 1'b1;
		new_ev.delta_ticks = first_q ? min_q : 32'd0;
		new_ev.event_key = rdata_q.key;
		new_ev.expired_count = 6'(n_q + 1'b1);
		if (rdata_q.vel[7]) begin
			new_ev.status_byte = NOTE_ON_BASE | {4'h0, rdata_q.ch};
			new_ev.event_velocity = 7'd0;
		end else begin
			new_ev.status_byte = NOTE_OFF_BASE | {4'h0, rdata_q.ch};
			new_ev.event_velocity = rdata_q.vel[6:0];
		end
	end

	// Final result of the command: the held release or an empty beat, with the delay left.
	always_comb begin
		if (pend_v_q) begin
			fin_ev = pend_q;
		end else begin
			fin_ev = '0;
		end
		fin_ev.remaining_ticks = delay_q;
		fin_ev.last = 1'b1;
	end

	// Table write port: append, clip during flush, or compact during a pass.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q[NA_W-1:0];
		mem_wdata = rdata_q;
		case (state_q)
			ST_IDLE: begin
				mem_we = cmd_take && (cmd.operation == OP_ADD)
					&& (count_q < NC_W'(MAX_NOTES));
				mem_waddr = count_q[NA_W-1:0];
				mem_wdata.ch = cmd.channel;
				mem_wdata.key = cmd.note_key;
				mem_wdata.vel = cmd.release_velocity;
				mem_wdata.left = cmd.ticks;
			end
			ST_FL_EV: begin
				mem_we = cut_q && (rdata_q.left > delay_q);
				mem_wdata.left = delay_q;
			end
			ST_SUB_EV: begin
				mem_we = (new_left != 32'd0);
				mem_waddr = wr_q[NA_W-1:0];
				mem_wdata.left = new_left;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Note table memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[idx_q[NA_W-1:0]];
	end

	// Payload registers of the pending and output results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SUB_EV: begin
				if (new_left == 32'd0 && (!pend_v_q || out_free)) begin
					pend_q <= new_ev;
					if (pend_v_q) begin
						out_q <= pend_q;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_q <= fin_ev;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			n_q <= '0;
			delay_q <= '0;
			min_q <= '0;
			cut_q <= 1'b0;
			first_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && evt_stall);
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						idx_q <= '0;
						n_q <= '0;
						cut_q <= cmd.cut_notes;
						case (cmd.operation)
							OP_ADD: begin
								delay_q <= '0;
								if (count_q < NC_W'(MAX_NOTES)) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_FINISH;
							end
							OP_ADVANCE: begin
								delay_q <= cmd.ticks;
								state_q <= ST_MIN_START;
							end
							OP_FLUSH: begin
								delay_q <= cmd.ticks;
								state_q <= ST_FL_RD;
							end
							default: begin
								delay_q <= '0;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				// Flush sweep: clip notes or raise the reference.
				ST_FL_RD: begin
					state_q <= (idx_q == count_q) ? ST_MIN_START : ST_FL_EV;
				end
				ST_FL_EV: begin
					if (!cut_q && rdata_q.left > delay_q) begin
						delay_q <= rdata_q.left;
					end
					idx_q <= idx_q + 1'b1;
					state_q <= ST_FL_RD;
				end
				// Minimum sweep over the held notes.
				ST_MIN_START: begin
					idx_q <= '0;
					min_q <= '1;
					state_q <= (count_q == '0) ? ST_FINISH : ST_MIN_RD;
				end
				ST_MIN_RD: begin
					state_q <= (idx_q == count_q) ? ST_MIN_CHK : ST_MIN_EV;
				end
				ST_MIN_EV: begin
					if (rdata_q.left < min_q) begin
						min_q <= rdata_q.left;
					end
					idx_q <= idx_q + 1'b1;
					state_q <= ST_MIN_RD;
				end
				ST_MIN_CHK: begin
					idx_q <= '0;
					wr_q <= '0;
					first_q <= 1'b1;
					if (min_q > delay_q) begin
						state_q <= ST_FINISH;
					end else begin
						delay_q <= delay_q - min_q;
						state_q <= ST_SUB_RD;
					end
				end
				// Subtract the step and retire expired notes, compacting in place.
				ST_SUB_RD: begin
					if (idx_q == count_q) begin
						count_q <= wr_q;
						state_q <= ST_MIN_START;
					end else begin
						state_q <= ST_SUB_EV;
					end
				end
				ST_SUB_EV: begin
					if (new_left != 32'd0) begin
						wr_q <= wr_q + 1'b1;
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SUB_RD;
					end else if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						n_q <= n_q + 1'b1;
						first_q <= 1'b0;
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SUB_RD;
					end
				end
				// Hand over the final result of the command.
				ST_FINISH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The table never holds more notes than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NC_W'(MAX_NOTES))
		else $error("note count exceeds table size");

	// No release event waits while the block is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending event left behind in idle");

	// A result without an event is always the only and final one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !evt.event_valid) |-> (evt.last && evt.expired_count == 6'd0))
		else $error("empty result not marked last");

	// Every release event counts itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_valid) |-> (evt.expired_count != 6'd0))
		else $error("release event with zero count");

	// On finish with a free output, the block goes idle with the final result on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (state_q == ST_IDLE && evt_valid && evt.last))
		else $error("final result not delivered on finish");

endmodule

@@ sim/mrne_release_checker.sv @@
`timescale 1ns / 1ps

module mrne_release_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input mrne_pkg::cmd_t cmd,
	input logic evt_valid,
	input logic evt_stall,
	input mrne_pkg::evt_t evt,
	output int fail_count,
	output int outstanding
);
	import mrne_pkg::*;

	// Shadow copy of the sounding notes, kept in table order.
	note_t held_notes[MAX_NOTES];
	int held_count;

	// Release beats still owed by the block, oldest first.
	evt_t pending_releases[$];

	// Result of an item that releases nothing.
	function automatic evt_t quiet_result(input logic [31:0] remain);
		evt_t r;
		r = '0;
		r.remaining_ticks = remain;
		r.last = 1'b1;
		return r;
	endfunction

	// Text form of one result beat for the mismatch report.
	function automatic string show_beat(input evt_t e);
		string s;
		s = $sformatf("valid=%0b delta=%0d status=%h key=%0d",
			e.event_valid, e.delta_ticks, e.status_byte, e.event_key);
		s = {s, $sformatf(" vel=%0d remain=%0d count=%0d last=%0b",
			e.event_velocity, e.remaining_ticks, e.expired_count, e.last)};
		return s;
	endfunction

	// Runs expiry passes over the delay and queues one beat per retired note.
	// The newest beat is held back so that the remaining delay and the last
	// flag can be placed on it once the passes are over.
	task automatic expire_notes(input logic [31:0] delay_in);
		logic [31:0] delay;
		logic [31:0] step;
		logic [31:0] delta;
		int released;
		int i;
		int j;
		bit done;
		evt_t newest;
		evt_t cur;
		delay = delay_in;
		released = 0;
		done = 1'b0;
		newest = '0;
		while (held_count > 0 && !done) begin
			step = held_notes[0].left;
			for (i = 1; i < held_count; i++) begin
				if (held_notes[i].left < step) begin
					step = held_notes[i].left;
				end
			end
			if (step > delay) begin
				done = 1'b1;
			end else begin
				for (i = 0; i < held_count; i++) begin
					held_notes[i].left = held_notes[i].left - step;
				end
				delay = delay - step;
				delta = step;
				i = 0;
				while (i < held_count) begin
					if (held_notes[i].left != 0) begin
						i++;
					end else begin
						if (released > 0) begin
							pending_releases.push_back(newest);
						end
						cur = '0;
						cur.event_valid = 1'b1;
						cur.delta_ticks = delta;
						cur.event_key = held_notes[i].key;
						// A release velocity of 128 or more goes out as a zero-velocity note-on.
						if (!held_notes[i].vel[7]) begin
							cur.status_byte = NOTE_OFF_BASE | {4'h0, held_notes[i].ch};
							cur.event_velocity = held_notes[i].vel[6:0];
						end else begin
							cur.status_byte = NOTE_ON_BASE | {4'h0, held_notes[i].ch};
							cur.event_velocity = '0;
						end
						released++;
						cur.expired_count = released[5:0];
						newest = cur;
						delta = '0;
						// Close the gap so the surviving notes keep their order.
						for (j = i; j < held_count - 1; j++) begin
							held_notes[j] = held_notes[j + 1];
						end
						held_count--;
					end
				end
			end
		end
		if (released == 0) begin
			pending_releases.push_back(quiet_result(delay));
		end else begin
			newest.remaining_ticks = delay;
			newest.last = 1'b1;
			pending_releases.push_back(newest);
		end
	endtask

	// Works out the beats that one accepted command causes.
	task automatic predict_releases(input cmd_t c);
		logic [31:0] ref_ticks;
		int i;
		case (c.operation)
			OP_ADD: begin
				// A full table drops the note without notice.
				if (held_count < MAX_NOTES) begin
					held_notes[held_count].ch = c.channel;
					held_notes[held_count].key = c.note_key;
					held_notes[held_count].vel = c.release_velocity;
					held_notes[held_count].left = c.ticks;
					held_count++;
				end
				pending_releases.push_back(quiet_result('0));
			end
			OP_ADVANCE: begin
				expire_notes(c.ticks);
			end
			OP_FLUSH: begin
				// Either clip long notes to the reference or stretch the reference.
				ref_ticks = c.ticks;
				for (i = 0; i < held_count; i++) begin
					if (held_notes[i].left > ref_ticks) begin
						if (c.cut_notes) begin
							held_notes[i].left = ref_ticks;
						end else begin
							ref_ticks = held_notes[i].left;
						end
					end
				end
				expire_notes(ref_ticks);
			end
			default: begin
				pending_releases.push_back(quiet_result('0));
			end
		endcase
	endtask

	// Compares one accepted result beat with the oldest expectation.
	task automatic check_release(input evt_t got);
		evt_t want;
		bit bad;
		if (pending_releases.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: unexpected result beat: %s", $realtime, show_beat(got));
			end
		end else begin
			want = pending_releases.pop_front();
			bad = (got.event_valid !== want.event_valid) ||
				(got.delta_ticks !== want.delta_ticks) ||
				(got.status_byte !== want.status_byte) ||
				(got.event_key !== want.event_key) ||
				(got.event_velocity !== want.event_velocity) ||
				(got.remaining_ticks !== want.remaining_ticks) ||
				(got.expired_count !== want.expired_count) ||
				(got.last !== want.last);
			if (bad) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: result mismatch: expected %s", $realtime, show_beat(want));
					$display("%0t:                      got %s", $realtime, show_beat(got));
				end
			end
		end
	endtask

	// Watch both channels. A result beat is checked before a command beat at the
	// same edge, since a command's results can only come after it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			pending_releases.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (evt_valid && !evt_stall) begin
				check_release(evt);
			end
			if (cmd_valid && !cmd_stall) begin
				predict_releases(cmd);
			end
			outstanding = pending_releases.size();
		end
	end

endmodule

@@ sim/midi_running_note_expiry_tb.sv @@
`timescale 1ns / 1ps

module midi_running_note_expiry_tb;
	import mrne_pkg::*;

	// The one operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_beat;
	logic evt_valid;
	logic evt_stall;
	evt_t evt_beat;
	int fail_count;
	int outstanding;
	bit sender_quiet;

	midi_running_note_expiry u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd_beat),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt_beat)
	);

	mrne_release_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd_beat),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt_beat),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#100_000_000;
		$display("midi_running_note_expiry_tb: FAIL");
		$finish;
	end

	// Draws a note length or delay: mostly short, sometimes zero, huge or the maximum.
	function automatic logic [31:0] pick_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(0, 40);
		end else if (r < 72) begin
			return '0;
		end else if (r < 92) begin
			return $urandom;
		end
		return '1;
	endfunction

	// Builds a command with random content in the fields the operation ignores.
	function automatic cmd_t make_cmd(input logic [1:0] op, input logic [31:0] t,
		input logic cut);
		cmd_t c;
		c.operation = op;
		c.channel = 4'($urandom);
		c.note_key = 7'($urandom);
		c.release_velocity = 8'($urandom);
		c.ticks = t;
		c.cut_notes = cut;
		return c;
	endfunction

	// Offers one command beat after a random gap and returns at the falling edge
	// after it is taken. Valid stays high into the next beat when there is no gap.
	task automatic offer_command(input cmd_t c);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			sender_quiet = !sender_quiet;
		end
		gap = sender_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_beat <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic add_note(input logic [3:0] ch, input logic [6:0] key,
		input logic [7:0] vel, input logic [31:0] t);
		cmd_t c;
		c = make_cmd(OP_ADD, t, 1'($urandom));
		c.channel = ch;
		c.note_key = key;
		c.release_velocity = vel;
		offer_command(c);
	endtask

	// Receiver: stalls a random number of cycles after each result beat, with
	// quiet stretches, and once holds off for a long time so the block backs up.
	initial begin
		int gap;
		int taken;
		bit quiet;
		taken = 0;
		quiet = 1'b0;
		evt_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && evt_valid && !evt_stall) begin
				taken++;
				if ($urandom_range(0, 39) == 0) begin
					quiet = !quiet;
				end
				gap = quiet ? 0 : $urandom_range(0, 5);
				if (taken == 150) begin
					gap = 400;
				end
				if (gap > 0) begin
					@(negedge clk);
					evt_stall <= 1'b1;
					repeat (gap) @(negedge clk);
					evt_stall <= 1'b0;
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int k;
		int r;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_beat = '0;
		sender_quiet = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Empty table, then the ignored operation code.
		offer_command(make_cmd(OP_ADVANCE, 32'd5, 1'b0));
		offer_command(make_cmd(OP_UNUSED, $urandom, 1'($urandom)));

		// Field extremes, a zero-length note and both release forms.
		add_note(4'd0, 7'd0, 8'd0, 32'd0);
		add_note(4'd15, 7'd127, 8'd127, 32'd10);
		add_note(4'd5, 7'd60, 8'd128, 32'd10);
		add_note(4'd3, 7'd64, 8'd255, '1);
		add_note(4'd9, 7'd1, 8'd64, 32'd3);
		// The zero-length note goes at once; then a delay too short to reach anything.
		offer_command(make_cmd(OP_ADVANCE, 32'd0, 1'b0));
		offer_command(make_cmd(OP_ADVANCE, 32'd2, 1'b0));
		// The largest delay retires the rest, two of them in one pass.
		offer_command(make_cmd(OP_ADVANCE, '1, 1'b0));

		// Flush in cut mode clips the long note to the reference.
		add_note(4'd1, 7'd20, 8'd10, 32'd100);
		add_note(4'd2, 7'd21, 8'd200, 32'd50);
		offer_command(make_cmd(OP_FLUSH, 32'd70, 1'b1));
		// Flush without cut stretches the reference to the longest note.
		add_note(4'd4, 7'd30, 8'd5, 32'd100);
		add_note(4'd6, 7'd31, 8'd1, 32'd20);
		offer_command(make_cmd(OP_FLUSH, 32'd30, 1'b0));
		// Flush of an empty table and of notes shorter than the reference.
		offer_command(make_cmd(OP_FLUSH, '1, 1'b0));
		add_note(4'd7, 7'd40, 8'd127, 32'd5);
		offer_command(make_cmd(OP_FLUSH, 32'd40, 1'b1));
		// Alternating bit patterns, then a zero reference that clips both.
		add_note(4'd10, 7'h55, 8'haa, 32'haaaa_aaaa);
		add_note(4'd5, 7'h2a, 8'h55, 32'h5555_5555);
		offer_command(make_cmd(OP_FLUSH, 32'd0, 1'b1));

		// Random traffic, with a burst now and then that overfills the table.
		k = 0;
		while (k < 480) begin
			if (k % 160 == 80) begin
				repeat (MAX_NOTES + 3) begin
					add_note(4'($urandom), 7'($urandom), 8'($urandom),
						$urandom_range(1, 40));
				end
				k += MAX_NOTES + 3;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					add_note(4'($urandom), 7'($urandom), 8'($urandom), pick_ticks());
				end else if (r < 75) begin
					offer_command(make_cmd(OP_ADVANCE, pick_ticks(), 1'($urandom)));
				end else if (r < 93) begin
					offer_command(make_cmd(OP_FLUSH, pick_ticks(), 1'($urandom)));
				end else begin
					offer_command(make_cmd(OP_UNUSED, $urandom, 1'($urandom)));
				end
				k++;
			end
		end
		cmd_valid <= 1'b0;

		// Drain, then watch a while longer for stray beats.
		wait (outstanding == 0);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("midi_running_note_expiry_tb: PASS");
		end else begin
			$display("midi_running_note_expiry_tb: FAIL");
		end
		$finish;
	end

endmodule
